>>> sv/tag_id_frame_extractor_unit_assert.svh
// Assertion macros for the tag id frame extractor.
// Included by the modules that check their own control logic.
`ifndef TAG_ID_FRAME_EXTRACTOR_UNIT_ASSERT_SVH
`define TAG_ID_FRAME_EXTRACTOR_UNIT_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define TIFE_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tife assertion failed");

// Consequent checked in the cycle after the antecedent.
`define TIFE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tife assertion failed");

`endif

>>> sv/tife_pkg.sv
// Shared constants, types and codes of the tag id frame extractor.
// No dependencies; every module and interface imports this package.
package tife_pkg;

    localparam int FRAME_LIMIT = 49;
    localparam int LEAD_MAX    = 8;
    localparam int TERM_MAX    = 4;

    localparam int ADDR_W  = $clog2(FRAME_LIMIT);
    localparam int CNT_W   = $clog2(FRAME_LIMIT + 1);
    localparam int HIST_D  = ((LEAD_MAX > TERM_MAX) ? LEAD_MAX : TERM_MAX) - 1;

    localparam int LTEXT_W = 64;
    localparam int LLEN_W  = 4;
    localparam int TTEXT_W = 32;
    localparam int TLEN_W  = 3;
    localparam int CIDX_W  = 2;
    localparam int CDATA_W = 64;

    localparam logic [LTEXT_W-1:0] LEAD_TEXT_RST = 64'h0000_0000_204B_4341;
    localparam logic [LLEN_W-1:0]  LEAD_LEN_RST  = 4'd4;
    localparam logic [TTEXT_W-1:0] TERM_TEXT_RST = 32'h0000_0A0D;
    localparam logic [TLEN_W-1:0]  TERM_LEN_RST  = 3'd2;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_ID    = 2'd1,
        KIND_ABORT = 2'd2
    } t_kind;

    typedef enum logic [CIDX_W-1:0] {
        CFG_LEAD_TEXT = 2'd0,
        CFG_LEAD_LEN  = 2'd1,
        CFG_TERM_TEXT = 2'd2,
        CFG_TERM_LEN  = 2'd3
    } t_cfg_idx;

    // Lengths are already clamped to their legal ranges.
    typedef struct packed {
        logic [LTEXT_W-1:0] lead_text;
        logic [LLEN_W-1:0]  lead_len;
        logic [TTEXT_W-1:0] term_text;
        logic [TLEN_W-1:0]  term_len;
    } t_cfg;

    // Per-byte decision from the scanner to the frame buffer.
    typedef struct packed {
        logic              evt_valid;
        t_kind             evt_kind;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              drain_start;
        logic [ADDR_W-1:0] drain_last;
    } t_scan_res;

endpackage

>>> sv/tife_ifs.sv
// Valid/ready channel interfaces: received bytes, results, configuration writes.
// Depends on tife_pkg.
interface tife_rx_if import tife_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface tife_res_if import tife_pkg::*; ();
    logic       valid;
    logic       ready;
    t_kind      kind;
    logic [7:0] id_byte;
    logic       last;

    modport source (output valid, output kind, output id_byte, output last, input ready);
    modport sink (input valid, input kind, input id_byte, input last, output ready);
endinterface

interface tife_cfg_if import tife_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CIDX_W-1:0]  index;
    logic [CDATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> sv/tag_id_frame_extractor_unit.sv
// Byte-stream deframer: hunts the lead-in, collects id bytes up to the terminator.
// Start/abort events pass the stage and output registers; id bytes after a terminator
// pass the sequencer state, memory read/stage and output register. Throughput: 1 byte
// per cycle barring output stalls; a start/abort blocks input until it leaves the stage,
// a terminator while m id bytes leave the 49-entry memory one per cycle by one read port.
// Reset: synchronous active low; clears phase, fill, sequencer, valids, restores config.
module tag_id_frame_extractor_unit import tife_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tife_rx_if.sink    i_rx,
    tife_cfg_if.sink   i_cfg,
    tife_res_if.source o_res
);

    t_cfg      cfg;
    t_scan_res scan_res;
    logic      rx_ready;
    logic      rx_accept;

    assign i_rx.ready = rx_ready;
    assign rx_accept  = i_rx.valid && rx_ready;

    tife_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    tife_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (rx_accept),
        .i_rx_byte (i_rx.rx_byte),
        .i_cfg     (cfg),
        .o_res     (scan_res)
    );

    tife_drain u_drain (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_scan     (scan_res),
        .o_rx_ready (rx_ready),
        .o_res      (o_res)
    );

endmodule

>>> sv/tife_cfg.sv
// Configuration register file with length clamping.
// Depends on tife_pkg and tife_cfg_if.
module tife_cfg import tife_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tife_cfg_if.sink    i_cfg,
    output t_cfg        o_cfg
);

    logic [LTEXT_W-1:0] r_lead_text;
    logic [LLEN_W-1:0]  r_lead_len;
    logic [TTEXT_W-1:0] r_term_text;
    logic [TLEN_W-1:0]  r_term_len;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead_text <= LEAD_TEXT_RST;
            r_lead_len  <= LEAD_LEN_RST;
            r_term_text <= TERM_TEXT_RST;
            r_term_len  <= TERM_LEN_RST;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_LEAD_TEXT: r_lead_text <= i_cfg.data[LTEXT_W-1:0];
                CFG_LEAD_LEN:  r_lead_len  <= i_cfg.data[LLEN_W-1:0];
                CFG_TERM_TEXT: r_term_text <= i_cfg.data[TTEXT_W-1:0];
                CFG_TERM_LEN:  r_term_len  <= i_cfg.data[TLEN_W-1:0];
            endcase
        end
    end

    // zero acts as one, oversize acts as the maximum
    always_comb begin
        o_cfg.lead_text = r_lead_text;
        o_cfg.term_text = r_term_text;
        if (r_lead_len == '0) begin
            o_cfg.lead_len = LLEN_W'(1);
        end else if (r_lead_len > LLEN_W'(LEAD_MAX)) begin
            o_cfg.lead_len = LLEN_W'(LEAD_MAX);
        end else begin
            o_cfg.lead_len = r_lead_len;
        end
        if (r_term_len == '0) begin
            o_cfg.term_len = TLEN_W'(1);
        end else if (r_term_len > TLEN_W'(TERM_MAX)) begin
            o_cfg.term_len = TLEN_W'(TERM_MAX);
        end else begin
            o_cfg.term_len = r_term_len;
        end
    end

endmodule

>>> sv/tife_scan.sv
// Byte scanner: lead-in hunt with resync, terminator detection, fill tracking, overflow abort.
// Depends on tife_pkg and the assertion macro header.
`include "tag_id_frame_extractor_unit_assert.svh"

module tife_scan import tife_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_rx_byte,
    input  t_cfg       i_cfg,
    output t_scan_res  o_res
);

    logic             r_phase, n_phase;
    logic [CNT_W-1:0] r_fill, n_fill;
    logic [7:0]       r_hist [HIST_D];

    logic [7:0]        win [HIST_D+1];
    logic [LEAD_MAX:1] lead_hit;
    logic [TERM_MAX:1] term_hit;
    logic [CNT_W-1:0]  cnt_n;
    logic [CNT_W-1:0]  lead_l;
    logic [CNT_W-1:0]  term_l;
    logic [CNT_W-1:0]  best;
    logic              pre_hit;
    logic              tail_hit;

    // win[a] is the byte received a transfers ago, the current one at 0
    always_comb begin
        win[0] = i_rx_byte;
        for (int a = 1; a <= HIST_D; a++) begin
            win[a] = r_hist[a-1];
        end
    end

    // lead_hit[k]: the last k bytes equal the first k lead-in bytes
    always_comb begin
        for (int k = 1; k <= LEAD_MAX; k++) begin
            lead_hit[k] = 1'b1;
            for (int i = 0; i < k; i++) begin
                lead_hit[k] = lead_hit[k] & (win[k-1-i] == i_cfg.lead_text[8*i +: 8]);
            end
        end
        for (int t = 1; t <= TERM_MAX; t++) begin
            term_hit[t] = 1'b1;
            for (int i = 0; i < t; i++) begin
                term_hit[t] = term_hit[t] & (win[t-1-i] == i_cfg.term_text[8*i +: 8]);
            end
        end
    end

    assign cnt_n  = r_fill + CNT_W'(1);
    assign lead_l = CNT_W'(i_cfg.lead_len);
    assign term_l = CNT_W'(i_cfg.term_len);

    always_comb begin
        pre_hit  = 1'b0;
        tail_hit = 1'b0;
        best     = '0;
        for (int k = 1; k <= LEAD_MAX; k++) begin
            if (CNT_W'(k) == cnt_n && cnt_n <= lead_l) begin
                pre_hit = lead_hit[k];
            end
            // longest proper suffix no longer than the lead-in
            if (lead_hit[k] && CNT_W'(k) <= r_fill && CNT_W'(k) <= lead_l) begin
                best = CNT_W'(k);
            end
        end
        for (int t = 1; t <= TERM_MAX; t++) begin
            if (TLEN_W'(t) == i_cfg.term_len) begin
                tail_hit = term_hit[t] && (cnt_n > term_l);
            end
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_fill  = r_fill;
        o_res   = '0;
        if (i_accept) begin
            if (!r_phase) begin
                if (pre_hit) begin
                    if (cnt_n == lead_l) begin
                        o_res.evt_valid = 1'b1;
                        o_res.evt_kind  = KIND_START;
                        n_phase         = 1'b1;
                        n_fill          = '0;
                    end else begin
                        n_fill = cnt_n;
                    end
                end else begin
                    n_fill = best;
                end
            end else begin
                o_res.wr_en   = 1'b1;
                o_res.wr_addr = r_fill[ADDR_W-1:0];
                o_res.wr_data = i_rx_byte;
                if (tail_hit) begin
                    o_res.drain_start = 1'b1;
                    o_res.drain_last  = ADDR_W'(cnt_n - term_l - CNT_W'(1));
                    n_phase           = 1'b0;
                    n_fill            = '0;
                end else if (cnt_n >= CNT_W'(FRAME_LIMIT)) begin
                    o_res.evt_valid = 1'b1;
                    o_res.evt_kind  = KIND_ABORT;
                    n_phase         = 1'b0;
                    n_fill          = '0;
                end else begin
                    n_fill = cnt_n;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
            r_fill  <= '0;
        end else begin
            r_phase <= n_phase;
            r_fill  <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_hist[0] <= i_rx_byte;
            for (int a = 1; a < HIST_D; a++) begin
                r_hist[a] <= r_hist[a-1];
            end
        end
    end

    `TIFE_ASSERT(a_fill_bound, i_clk, i_rst_n, r_fill < CNT_W'(FRAME_LIMIT))
    `TIFE_ASSERT(a_hunt_fill, i_clk, i_rst_n, !r_phase |-> (r_fill <= CNT_W'(LEAD_MAX)))
    `TIFE_ASSERT_NEXT(a_start_clears, i_clk, i_rst_n, o_res.evt_valid && o_res.evt_kind == KIND_START, r_phase && r_fill == '0)

endmodule

>>> sv/tife_drain.sv
// Frame buffer memory, id byte read-out sequencer, staging and output register.
// Depends on tife_pkg, tife_res_if and the assertion macro header.
`include "tag_id_frame_extractor_unit_assert.svh"

module tife_drain import tife_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_scan_res  i_scan,
    output logic       o_rx_ready,
    tife_res_if.source o_res
);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_DRAIN = 2'b10
    } t_state;

    t_state            r_state;
    logic [7:0]        r_mem [FRAME_LIMIT];
    logic [7:0]        r_rd_q;
    logic [ADDR_W-1:0] r_ptr;
    logic [ADDR_W-1:0] r_last_idx;

    logic  r_stg_valid;
    t_kind r_stg_kind;
    logic  r_stg_last;

    logic       r_out_valid;
    t_kind      r_out_kind;
    logic [7:0] r_out_byte;
    logic       r_out_last;

    logic stg_move;
    logic stg_free;
    logic rd_en;

    assign stg_move   = r_stg_valid && (!r_out_valid || o_res.ready);
    assign stg_free   = !r_stg_valid || stg_move;
    assign rd_en      = (r_state == ST_DRAIN) && stg_free;
    assign o_rx_ready = (r_state == ST_IDLE) && !r_stg_valid;

    always_ff @(posedge i_clk) begin
        if (i_scan.wr_en) begin
            r_mem[i_scan.wr_addr] <= i_scan.wr_data;
        end
        if (rd_en) begin
            r_rd_q <= r_mem[r_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_ptr      <= '0;
            r_last_idx <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_scan.drain_start) begin
                        r_state    <= ST_DRAIN;
                        r_ptr      <= '0;
                        r_last_idx <= i_scan.drain_last;
                    end
                end
                ST_DRAIN: begin
                    if (rd_en) begin
                        r_ptr <= r_ptr + ADDR_W'(1);
                        if (r_ptr == r_last_idx) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // stage: holds an event or the tag of a byte whose read is in r_rd_q
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_valid <= 1'b0;
        end else if (i_scan.evt_valid || rd_en) begin
            r_stg_valid <= 1'b1;
        end else if (stg_move) begin
            r_stg_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_scan.evt_valid) begin
            r_stg_kind <= i_scan.evt_kind;
            r_stg_last <= 1'b1;
        end else if (rd_en) begin
            r_stg_kind <= KIND_ID;
            r_stg_last <= (r_ptr == r_last_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (stg_move) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_move) begin
            r_out_kind <= r_stg_kind;
            r_out_last <= r_stg_last;
            r_out_byte <= (r_stg_kind == KIND_ID) ? r_rd_q : 8'h00;
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.kind    = r_out_kind;
    assign o_res.id_byte = r_out_byte;
    assign o_res.last    = r_out_last;

    `TIFE_ASSERT(a_evt_when_free, i_clk, i_rst_n, i_scan.evt_valid |-> (!r_stg_valid && r_state == ST_IDLE))
    `TIFE_ASSERT(a_drain_from_idle, i_clk, i_rst_n, i_scan.drain_start |-> (r_state == ST_IDLE && !r_stg_valid))
    `TIFE_ASSERT(a_ptr_in_range, i_clk, i_rst_n, (r_state == ST_DRAIN) |-> (r_ptr <= r_last_idx))
    `TIFE_ASSERT_NEXT(a_drain_ends, i_clk, i_rst_n, rd_en && r_ptr == r_last_idx, r_state == ST_IDLE && r_stg_last)

endmodule
